// File: hdl/pvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvc_pkg
// Types, constants and colour ramp tables shared by the colouriser modules.
// ----------------------------------------------------------------------------
package pvc_pkg;

  localparam int VAL_W = 21;
  localparam int COORD_W = 20;
  localparam int QUEUE_DEPTH = 2;
  localparam int ROOT_STEPS = 21;
  localparam int DIV_STEPS = 17;

  localparam logic [1:0] MODE_INTENSITY = 2'd1;
  localparam logic [1:0] MODE_SPEED = 2'd2;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 21'sd1048575;
  localparam logic signed [VAL_W-1:0] VAL_MIN = -21'sd1048576;

  localparam logic [7:0] ALPHA_DIM = 8'd173;
  localparam logic [7:0] ALPHA_FULL = 8'd255;
  localparam logic [32:0] ROUND_HALF = 33'd3276800;
  localparam logic [12:0] RECIP_100 = 13'd5243;

  // Request travelling from the front to the back.
  typedef struct packed {
    logic                    store;
    logic                    last;
    logic                    dim;
    logic signed [VAL_W-1:0] value;
  } rec_t;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL, F_SUM, F_ROOT, F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE, B_READ, B_LOAD, B_DIV, B_RAMP, B_SCALE, B_QUOT
  } back_state_e;

  // Ramp base in hundredths, indexed by segment and channel.
  function automatic logic [7:0] ramp_base(input logic [1:0] seg, input logic [1:0] ch);
    logic [7:0] b;
    case ({seg, ch})
      4'h0: b = 8'd8;
      4'h1: b = 8'd25;
      4'h2: b = 8'd75;
      4'h4: b = 8'd8;
      4'h5: b = 8'd80;
      4'h6: b = 8'd90;
      4'h8: b = 8'd20;
      4'h9: b = 8'd92;
      4'hA: b = 8'd35;
      4'hC: b = 8'd95;
      4'hD: b = 8'd80;
      4'hE: b = 8'd10;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  // Ramp slope in hundredths, signed.
  function automatic logic signed [7:0] ramp_slope(input logic [1:0] seg,
                                                   input logic [1:0] ch);
    logic signed [7:0] s;
    case ({seg, ch})
      4'h0: s = 8'sd0;
      4'h1: s = 8'sd55;
      4'h2: s = 8'sd15;
      4'h4: s = 8'sd12;
      4'h5: s = 8'sd12;
      4'h6: s = -8'sd55;
      4'h8: s = 8'sd75;
      4'h9: s = -8'sd12;
      4'hA: s = -8'sd25;
      4'hC: s = 8'sd0;
      4'hD: s = -8'sd65;
      4'hE: s = 8'sd5;
      default: s = 8'sd0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// File: hdl/point_value_colorizer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_value_colorizer_core
// Min/max normalised colour ramp over one frame of lidar points.
// ----------------------------------------------------------------------------
// Loading: a distance point passes the squares, the sum and the 21-step root;
// intensity, velocity or invalid points skip the root and go straight to push.
// Emission: each stored point passes the 17-step divider and the three-stage
// ramp scaling; the back takes no new request until the frame is emitted.
// The receiver cannot stall: each result is strobed for one cycle.
// Reset is asynchronous and active low; it clears the frame state and mode.
// ----------------------------------------------------------------------------
//
// The front takes a request, latches its fields with the mode in force and
// computes the coloured value, using an iterative square root for distance.
// It hands a request to a two-entry queue, so the next point can be loaded
// while the back is still emitting colours for a previous frame. The back
// stores points, keeps the running extremes and, on frame end, walks the
// stored points in arrival order through a bit-serial divider and the ramp.
module point_value_colorizer_core #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_wdata_i,
  input  wire logic               point_valid_i,
  input  wire logic signed [19:0] x_mm_i,
  input  wire logic signed [19:0] y_mm_i,
  input  wire logic signed [19:0] z_mm_i,
  input  wire logic [15:0]        intensity_level_i,
  input  wire logic               intensity_ok_i,
  input  wire logic signed [15:0] speed_mm_s_i,
  input  wire logic               speed_ok_i,
  input  wire logic               is_interpolated_i,
  input  wire logic               frame_end_i,
  output logic                    result_valid_o,
  output logic [5:0]              point_number_o,
  output logic [7:0]              red_level_o,
  output logic [7:0]              green_level_o,
  output logic [7:0]              blue_level_o,
  output logic [7:0]              alpha_level_o,
  output logic                    run_end_o
);
  import pvc_pkg::*;

  logic [1:0] mode_q;
  rec_t front_rec, queue_rec;
  logic push, full, pop, empty;

  // Value mode register; to be written only while idle, which the block does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  pvc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .busy_o            (busy),
    .mode_i            (mode_q),
    .point_valid_i     (point_valid_i),
    .x_mm_i            (x_mm_i),
    .y_mm_i            (y_mm_i),
    .z_mm_i            (z_mm_i),
    .intensity_level_i (intensity_level_i),
    .intensity_ok_i    (intensity_ok_i),
    .speed_mm_s_i      (speed_mm_s_i),
    .speed_ok_i        (speed_ok_i),
    .is_interpolated_i (is_interpolated_i),
    .frame_end_i       (frame_end_i),
    .rec_o             (front_rec),
    .push_o            (push),
    .full_i            (full)
  );

  pvc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (front_rec),
    .full_o  (full),
    .pop_i   (pop),
    .rec_o   (queue_rec),
    .empty_o (empty)
  );

  pvc_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rec_i          (queue_rec),
    .empty_i        (empty),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .point_number_o (point_number_o),
    .red_level_o    (red_level_o),
    .green_level_o  (green_level_o),
    .blue_level_o   (blue_level_o),
    .alpha_level_o  (alpha_level_o),
    .run_end_o      (run_end_o)
  );

endmodule
`default_nettype wire

// File: hdl/pvc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvc_front
// Accepts points, picks the coloured value and computes the distance root.
// ----------------------------------------------------------------------------
module pvc_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [1:0]                   mode_i,
  input  wire logic                         point_valid_i,
  input  wire logic signed [19:0]           x_mm_i,
  input  wire logic signed [19:0]           y_mm_i,
  input  wire logic signed [19:0]           z_mm_i,
  input  wire logic [15:0]                  intensity_level_i,
  input  wire logic                         intensity_ok_i,
  input  wire logic signed [15:0]           speed_mm_s_i,
  input  wire logic                         speed_ok_i,
  input  wire logic                         is_interpolated_i,
  input  wire logic                         frame_end_i,
  output pvc_pkg::rec_t                     rec_o,
  output logic                              push_o,
  input  wire logic                         full_i
);
  import pvc_pkg::*;

  front_state_e state_q, state_d;
  logic signed [COORD_W-1:0] x_q, y_q, z_q;
  logic [38:0] sqx_q, sqy_q, sqz_q;
  logic [41:0] rad_q, rad_d;
  logic [23:0] rem_q, rem_d;
  logic [20:0] root_q, root_d;
  logic [4:0] step_q, step_d;
  logic store_q, last_q, dim_q;
  logic signed [VAL_W-1:0] value_q, value_d;
  logic accept, need_root;
  logic signed [39:0] px, py, pz;
  logic [23:0] rem_sh, trial;

  assign accept = start_i && (state_q == F_IDLE);
  assign need_root = point_valid_i &&
                     !((mode_i == MODE_INTENSITY) && intensity_ok_i) &&
                     !((mode_i == MODE_SPEED) && speed_ok_i);

  assign px = x_q * x_q;
  assign py = y_q * y_q;
  assign pz = z_q * z_q;
  assign rem_sh = {rem_q[21:0], rad_q[41:40]};
  assign trial = {1'b0, root_q, 2'b01};

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (start_i) state_d = need_root ? F_MUL : F_PUSH;
      F_MUL:   state_d = F_SUM;
      F_SUM:   state_d = F_ROOT;
      F_ROOT:  if (step_q == 5'(ROOT_STEPS - 1)) state_d = F_PUSH;
      F_PUSH:  if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    value_d = value_q;
    rad_d = rad_q;
    rem_d = rem_q;
    root_d = root_q;
    step_d = step_q;
    case (state_q)
      F_IDLE: begin
        if ((mode_i == MODE_INTENSITY) && intensity_ok_i) begin
          value_d = VAL_W'($signed({1'b0, intensity_level_i}));
        end else begin
          value_d = VAL_W'(speed_mm_s_i);
        end
      end
      F_SUM: begin
        rad_d = 42'(sqx_q) + 42'(sqy_q) + 42'(sqz_q);
        rem_d = '0;
        root_d = '0;
        step_d = '0;
      end
      F_ROOT: begin
        rad_d = {rad_q[39:0], 2'b00};
        step_d = step_q + 5'd1;
        if (rem_sh >= trial) begin
          rem_d = rem_sh - trial;
          root_d = {root_q[19:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          root_d = {root_q[19:0], 1'b0};
        end
        if (step_q == 5'(ROOT_STEPS - 1)) value_d = $signed(root_d);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= x_mm_i;
      y_q <= y_mm_i;
      z_q <= z_mm_i;
      store_q <= point_valid_i;
      last_q <= frame_end_i;
      dim_q <= is_interpolated_i;
    end
    if (state_q == F_MUL) begin
      sqx_q <= px[38:0];
      sqy_q <= py[38:0];
      sqz_q <= pz[38:0];
    end
    value_q <= value_d;
    rad_q <= rad_d;
    rem_q <= rem_d;
    root_q <= root_d;
    step_q <= step_d;
  end

  assign busy_o = (state_q != F_IDLE);
  assign push_o = (state_q == F_PUSH) && !full_i;
  assign rec_o = '{store: store_q, last: last_q, dim: dim_q, value: value_q};

endmodule
`default_nettype wire

// File: hdl/pvc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvc_queue
// Short queue of requests between the front and the back.
// ----------------------------------------------------------------------------
module pvc_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  pvc_pkg::rec_t      rec_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output pvc_pkg::rec_t      rec_o,
  output logic               empty_o
);
  import pvc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  rec_t slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0] cnt_q;

  assign full_o = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rec_o = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= rec_i;
  end

endmodule
`default_nettype wire

// File: hdl/pvc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvc_back
// Stores points, tracks the extremes and emits the ramp colour per point.
// ----------------------------------------------------------------------------
module pvc_back #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  pvc_pkg::rec_t      rec_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  output logic               result_valid_o,
  output logic [5:0]         point_number_o,
  output logic [7:0]         red_level_o,
  output logic [7:0]         green_level_o,
  output logic [7:0]         blue_level_o,
  output logic [7:0]         alpha_level_o,
  output logic               run_end_o
);
  import pvc_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  back_state_e state_q, state_d;
  logic signed [VAL_W-1:0] value_mem [MAX_POINTS];
  logic dim_mem [MAX_POINTS];
  logic signed [VAL_W-1:0] rd_value_q;
  logic rd_dim_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic signed [VAL_W-1:0] min_q, min_d, max_q, max_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [22:0] span_q, rem_q, rem_d;
  logic [16:0] quo_q, quo_d;
  logic [4:0] step_q, step_d;
  logic signed [24:0] acc_q [3];
  logic [16:0] m_q [3];
  logic wr_en, is_last;
  logic signed [22:0] span_c, diff_c;
  logic [22:0] rem_cand;
  logic div_bit;
  logic [15:0] t_c;
  logic [15:0] u_c;
  logic [7:0] lvl_c [3];
  logic valid_q, run_end_q, dim_out_q;
  logic [IDX_W-1:0] num_q;
  logic [7:0] lvl_q [3];

  assign pop_o = (state_q == B_IDLE) && !empty_i;
  assign wr_en = pop_o && rec_i.store && (count_q < CNT_W'(MAX_POINTS));
  assign is_last = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;

  assign span_c = 23'(max_q) - 23'(min_q);
  assign diff_c = 23'(rd_value_q) - 23'(min_q);
  assign rem_cand = (step_q == '0) ? rem_q : {rem_q[21:0], 1'b0};
  assign div_bit = (rem_cand >= span_q);
  assign t_c = quo_q[16] ? 16'hFFFF : quo_q[15:0];
  assign u_c = {t_c[13:0], 2'b00};

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (pop_o && rec_i.last) state_d = (count_d == '0) ? B_IDLE : B_READ;
      end
      B_READ:  state_d = B_LOAD;
      B_LOAD:  state_d = B_DIV;
      B_DIV:   if (step_q == 5'(DIV_STEPS - 1)) state_d = B_RAMP;
      B_RAMP:  state_d = B_SCALE;
      B_SCALE: state_d = B_QUOT;
      B_QUOT:  state_d = is_last ? B_IDLE : B_READ;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    count_d = count_q;
    min_d = min_q;
    max_d = max_q;
    idx_d = idx_q;
    rem_d = rem_q;
    quo_d = quo_q;
    step_d = step_q;
    case (state_q)
      B_IDLE: begin
        if (wr_en) begin
          count_d = count_q + CNT_W'(1);
          if (rec_i.value < min_q) min_d = rec_i.value;
          if (rec_i.value > max_q) max_d = rec_i.value;
        end
        idx_d = '0;
        if (pop_o && rec_i.last && (count_d == '0)) begin
          min_d = VAL_MAX;
          max_d = VAL_MIN;
        end
      end
      B_LOAD: begin
        rem_d = diff_c[22] ? '0 : diff_c;
        quo_d = '0;
        step_d = '0;
      end
      B_DIV: begin
        rem_d = div_bit ? (rem_cand - span_q) : rem_cand;
        quo_d = {quo_q[15:0], div_bit};
        step_d = step_q + 5'd1;
      end
      B_QUOT: begin
        if (is_last) begin
          count_d = '0;
          min_d = VAL_MAX;
          max_d = VAL_MIN;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Final scaling: level = floor(m / 100), saturated.
  always_comb begin
    logic [29:0] prod;
    for (int c = 0; c < 3; c++) begin
      prod = 30'(m_q[c]) * 30'(RECIP_100);
      lvl_c[c] = (prod[29:19] > 11'd255) ? 8'd255 : prod[26:19];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      count_q <= '0;
      min_q <= VAL_MAX;
      max_q <= VAL_MIN;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      min_q <= min_d;
      max_q <= max_d;
      valid_q <= (state_q == B_QUOT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      value_mem[count_q[IDX_W-1:0]] <= rec_i.value;
      dim_mem[count_q[IDX_W-1:0]] <= rec_i.dim;
    end
    rd_value_q <= value_mem[idx_q];
    rd_dim_q <= dim_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    step_q <= step_d;
    if (state_q == B_READ) span_q <= (span_c < 23'sd1) ? 23'd1 : span_c;
    if (state_q == B_RAMP) begin
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= $signed({1'b0, ramp_base(t_c[15:14], 2'(c)), 16'h0000}) +
                    25'(ramp_slope(t_c[15:14], 2'(c)) * $signed({1'b0, u_c}));
      end
    end
    if (state_q == B_SCALE) begin
      for (int c = 0; c < 3; c++) begin
        m_q[c] <= 17'(((33'(acc_q[c][24] ? 24'd0 : acc_q[c][23:0]) * 33'd255) +
                       ROUND_HALF) >> 16);
      end
    end
    if (state_q == B_QUOT) begin
      lvl_q <= lvl_c;
      num_q <= idx_q;
      dim_out_q <= rd_dim_q;
      run_end_q <= is_last;
    end
  end

  assign result_valid_o = valid_q;
  assign point_number_o = 6'(num_q);
  assign red_level_o = lvl_q[0];
  assign green_level_o = lvl_q[1];
  assign blue_level_o = lvl_q[2];
  assign alpha_level_o = dim_out_q ? ALPHA_DIM : ALPHA_FULL;
  assign run_end_o = run_end_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POINTS)) else $error("stored count beyond capacity");
  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(state_q == B_QUOT)) else $error("strobe without result");
  a_span_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV) |-> (span_q != '0)) else $error("zero span in divider");
  a_frame_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && run_end_q) |-> (count_q == '0)) else $error("frame not cleared");
`endif

endmodule
`default_nettype wire
